// ===== hdl/cnms_pkg.sv =====
package cnms_pkg;

    // Internal field widths; the year keeps one extra bit so the search position can
    // count past year 4095.
    localparam int YEAR_W   = 13;
    localparam int YMOD_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 60;

    // Length of the leap cycle
    localparam logic [YMOD_W-1:0] LEAP_CYCLE = 12'd400;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MDAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WDAY   = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CLAMP,
        ST_FIRST,
        ST_SEARCH
    } t_state;

    // Days in a month; the month is already within 1..12
    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Gregorian leap test on the year taken modulo 400
    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        return (ymod[1:0] == 2'b00) && (ymod != 12'd100) && (ymod != 12'd200)
            && (ymod != 12'd300);
    endfunction

endpackage

// ===== hdl/cron_next_match_search.sv =====
// Sequence: ST_MOD reduces the year modulo 400 by repeated subtraction, ST_CLAMP clamps the day,
// ST_FIRST moves to the following whole minute, ST_SEARCH takes one search step at a time, and then the
// result is registered. A step moves a day, an hour or a minute, so with an empty minute mask a miss
// takes about 1440 * (MAX_SEARCH_DAYS + 1) steps. Throughput: one query at a time.
// busy drops in the result beat; the result stands for one cycle with o_valid, no stall.
// Reset (synchronous, active low) sets all masks to ones and returns the sequencer to idle.
module cron_next_match_search #(
    parameter int MAX_SEARCH_DAYS = 2922
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [cnms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cnms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [11:0] i_now_year,
    input  logic [3:0]  i_now_month,
    input  logic [4:0]  i_now_day,
    input  logic [2:0]  i_now_weekday,
    input  logic [4:0]  i_now_hour,
    input  logic [5:0]  i_now_minute,
    output logic        o_valid,
    output logic        o_found,
    output logic [11:0] o_next_year,
    output logic [3:0]  o_next_month,
    output logic [4:0]  o_next_day,
    output logic [2:0]  o_next_weekday,
    output logic [4:0]  o_next_hour,
    output logic [5:0]  o_next_minute
);

    localparam int DC_W = $clog2(MAX_SEARCH_DAYS + 2);
    localparam logic [DC_W-1:0] DAY_LIMIT = DC_W'(MAX_SEARCH_DAYS);

    // Configuration masks
    logic [59:0] r_minute_mask;
    logic [23:0] r_hour_mask;
    logic [30:0] r_mday_mask;
    logic [11:0] r_month_mask;
    logic [6:0]  r_wday_mask;

    // Sequencer and search position
    cnms_pkg::t_state r_state, n_state;
    logic [cnms_pkg::YEAR_W-1:0] r_cy, n_cy;
    logic [cnms_pkg::YMOD_W-1:0] r_ymod, n_ymod;
    logic [3:0]      r_cm, n_cm;
    logic [4:0]      r_cd, n_cd;
    logic [2:0]      r_cw, n_cw;
    logic [4:0]      r_ch, n_ch;
    logic [5:0]      r_cmin, n_cmin;
    logic [DC_W-1:0] r_dc, n_dc;

    // Result registers
    logic        r_valid, n_valid;
    logic        r_found, n_found;
    logic [11:0] r_oy, n_oy;
    logic [3:0]  r_om, n_om;
    logic [4:0]  r_od, n_od;
    logic [2:0]  r_ow, n_ow;
    logic [4:0]  r_oh, n_oh;
    logic [5:0]  r_omin, n_omin;

    // Shared date step unit: the position one day on
    logic                        leap;
    logic [4:0]                  dim;
    logic [cnms_pkg::YEAR_W-1:0] d_cy;
    logic [cnms_pkg::YMOD_W-1:0] d_ymod;
    logic [3:0]                  d_cm;
    logic [4:0]                  d_cd;
    logic [2:0]                  d_cw;

    // Match tests and search outcome
    logic date_fail, hour_fail, min_fail, limit_hit, search_end;

    always_comb begin
        leap   = cnms_pkg::is_leap(r_ymod);
        dim    = cnms_pkg::days_in_month(r_cm, leap);
        d_cw   = (r_cw == 3'd6) ? 3'd0 : r_cw + 3'd1;
        d_cy   = r_cy;
        d_ymod = r_ymod;
        d_cm   = r_cm;
        d_cd   = r_cd + 5'd1;
        if (r_cd >= dim) begin
            d_cd = 5'd1;
            if (r_cm == 4'd12) begin
                d_cm   = 4'd1;
                d_cy   = r_cy + cnms_pkg::YEAR_W'(1);
                d_ymod = (r_ymod == cnms_pkg::LEAP_CYCLE - 12'd1) ? '0 : r_ymod + 12'd1;
            end else begin
                d_cm = r_cm + 4'd1;
            end
        end
    end

    // Test the masks at the current position
    always_comb begin
        date_fail  = !r_month_mask[r_cm - 4'd1] || !r_mday_mask[r_cd - 5'd1]
                  || !r_wday_mask[r_cw];
        hour_fail  = !r_hour_mask[r_ch];
        min_fail   = !r_minute_mask[r_cmin];
        limit_hit  = r_dc > DAY_LIMIT;
        search_end = limit_hit || (!date_fail && !hour_fail && !min_fail);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cnms_pkg::ST_IDLE:   if (start) n_state = cnms_pkg::ST_MOD;
            cnms_pkg::ST_MOD:    if (r_ymod < cnms_pkg::LEAP_CYCLE) n_state = cnms_pkg::ST_CLAMP;
            cnms_pkg::ST_CLAMP:  n_state = cnms_pkg::ST_FIRST;
            cnms_pkg::ST_FIRST:  n_state = cnms_pkg::ST_SEARCH;
            cnms_pkg::ST_SEARCH: if (search_end) n_state = cnms_pkg::ST_IDLE;
            default:             n_state = cnms_pkg::ST_IDLE;
        endcase
    end

    // Datapath and result
    always_comb begin
        n_cy    = r_cy;
        n_ymod  = r_ymod;
        n_cm    = r_cm;
        n_cd    = r_cd;
        n_cw    = r_cw;
        n_ch    = r_ch;
        n_cmin  = r_cmin;
        n_dc    = r_dc;
        n_valid = 1'b0;
        n_found = r_found;
        n_oy    = r_oy;
        n_om    = r_om;
        n_od    = r_od;
        n_ow    = r_ow;
        n_oh    = r_oh;
        n_omin  = r_omin;
        unique case (r_state)
            cnms_pkg::ST_IDLE: begin
                // Load and clamp the query
                if (start) begin
                    n_cy   = {1'b0, i_now_year};
                    n_ymod = i_now_year;
                    n_cm   = (i_now_month == 4'd0) ? 4'd1
                           : (i_now_month > 4'd12) ? 4'd12 : i_now_month;
                    n_cd   = (i_now_day == 5'd0) ? 5'd1 : i_now_day;
                    n_cw   = (i_now_weekday == 3'd7) ? 3'd0 : i_now_weekday;
                    n_ch   = (i_now_hour > 5'd23) ? 5'd23 : i_now_hour;
                    n_cmin = (i_now_minute > 6'd59) ? 6'd59 : i_now_minute;
                    n_dc   = '0;
                end
            end
            cnms_pkg::ST_MOD: begin
                // Reduce the year modulo 400
                if (r_ymod >= cnms_pkg::LEAP_CYCLE) n_ymod = r_ymod - cnms_pkg::LEAP_CYCLE;
            end
            cnms_pkg::ST_CLAMP: begin
                if (r_cd > dim) n_cd = dim;
            end
            cnms_pkg::ST_FIRST: begin
                // Advance to the following whole minute
                if (r_cmin == 6'd59) begin
                    n_cmin = '0;
                    if (r_ch == 5'd23) begin
                        n_ch = '0;
                        n_cy = d_cy; n_ymod = d_ymod; n_cm = d_cm; n_cd = d_cd; n_cw = d_cw;
                        n_dc = r_dc + DC_W'(1);
                    end else begin
                        n_ch = r_ch + 5'd1;
                    end
                end else begin
                    n_cmin = r_cmin + 6'd1;
                end
            end
            cnms_pkg::ST_SEARCH: begin
                if (limit_hit) begin
                    // Give up: zero result
                    n_valid = 1'b1;
                    n_found = 1'b0;
                    n_oy    = '0;
                    n_om    = '0;
                    n_od    = '0;
                    n_ow    = '0;
                    n_oh    = '0;
                    n_omin  = '0;
                end else if (date_fail) begin
                    // Jump to midnight of the next day
                    n_cy = d_cy; n_ymod = d_ymod; n_cm = d_cm; n_cd = d_cd; n_cw = d_cw;
                    n_dc   = r_dc + DC_W'(1);
                    n_ch   = '0;
                    n_cmin = '0;
                end else if (hour_fail || (min_fail && r_cmin == 6'd59)) begin
                    // Jump to the top of the next hour
                    n_cmin = '0;
                    if (r_ch == 5'd23) begin
                        n_ch = '0;
                        n_cy = d_cy; n_ymod = d_ymod; n_cm = d_cm; n_cd = d_cd; n_cw = d_cw;
                        n_dc = r_dc + DC_W'(1);
                    end else begin
                        n_ch = r_ch + 5'd1;
                    end
                end else if (min_fail) begin
                    n_cmin = r_cmin + 6'd1;
                end else begin
                    // Match: publish the position
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_oy    = r_cy[11:0];
                    n_om    = r_cm;
                    n_od    = r_cd;
                    n_ow    = r_cw;
                    n_oh    = r_ch;
                    n_omin  = r_cmin;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= cnms_pkg::ST_IDLE;
            r_valid       <= 1'b0;
            r_minute_mask <= '1;
            r_hour_mask   <= '1;
            r_mday_mask   <= '1;
            r_month_mask  <= '1;
            r_wday_mask   <= '1;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cnms_pkg::CFG_MINUTE: r_minute_mask <= i_cfg_data[59:0];
                    cnms_pkg::CFG_HOUR:   r_hour_mask   <= i_cfg_data[23:0];
                    cnms_pkg::CFG_MDAY:   r_mday_mask   <= i_cfg_data[30:0];
                    cnms_pkg::CFG_MONTH:  r_month_mask  <= i_cfg_data[11:0];
                    cnms_pkg::CFG_WDAY:   r_wday_mask   <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cy    <= n_cy;
        r_ymod  <= n_ymod;
        r_cm    <= n_cm;
        r_cd    <= n_cd;
        r_cw    <= n_cw;
        r_ch    <= n_ch;
        r_cmin  <= n_cmin;
        r_dc    <= n_dc;
        r_found <= n_found;
        r_oy    <= n_oy;
        r_om    <= n_om;
        r_od    <= n_od;
        r_ow    <= n_ow;
        r_oh    <= n_oh;
        r_omin  <= n_omin;
    end

    assign busy           = (r_state != cnms_pkg::ST_IDLE);
    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_next_year    = r_oy;
    assign o_next_month   = r_om;
    assign o_next_day     = r_od;
    assign o_next_weekday = r_ow;
    assign o_next_hour    = r_oh;
    assign o_next_minute  = r_omin;

    // An accepted query leaves idle at once
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("query accepted but sequencer stayed idle");

    // A result beat only ends a search
    a_valid_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == cnms_pkg::ST_SEARCH)
        else $error("result beat outside of a search");

    // During the search the position stays in range
    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cnms_pkg::ST_SEARCH |-> r_ymod < cnms_pkg::LEAP_CYCLE
            && r_cmin <= 6'd59 && r_ch <= 5'd23 && r_cd <= dim
            && r_dc <= DAY_LIMIT + DC_W'(1))
        else $error("search position out of range");

    // A miss carries an all zero result
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> $past(limit_hit) && o_next_year == 12'd0
            && o_next_month == 4'd0 && o_next_day == 5'd0)
        else $error("miss result not cleared or not at the day limit");

endmodule

// ===== sim/tb_cron_next_match_search.sv =====
module tb_cron_next_match_search;

    localparam int SEARCH_DAYS = 2922;
    // cycles without any beat before the run is declared hung; an empty minute mask
    // with every other mask open walks about 1440 steps a day up to the day limit
    localparam int HANG_LIMIT  = 20000000;
    // quiet tail after the last result, to catch stray beats
    localparam int DRAIN_CYCLES = 3100;

    // indexes past the five mask registers; writes there must be dropped
    localparam logic [cnms_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [cnms_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_now;

    typedef struct packed {
        logic        found;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_match;

    // one planned beat: a query or a register write
    typedef struct packed {
        logic                            is_cfg;
        logic                            hurry;
        logic                            hold_idle;
        logic [cnms_pkg::CFG_IDX_W-1:0]  idx;
        logic [cnms_pkg::CFG_DATA_W-1:0] data;
        t_now                            now;
    } t_request;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            i_cfg_we = 1'b0;
    logic [cnms_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [cnms_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic [11:0]           i_now_year = '0;
    logic [3:0]            i_now_month = '0;
    logic [4:0]            i_now_day = '0;
    logic [2:0]            i_now_weekday = '0;
    logic [4:0]            i_now_hour = '0;
    logic [5:0]            i_now_minute = '0;
    logic                  o_valid;
    logic                  o_found;
    logic [11:0]           o_next_year;
    logic [3:0]            o_next_month;
    logic [4:0]            o_next_day;
    logic [2:0]            o_next_weekday;
    logic [4:0]            o_next_hour;
    logic [5:0]            o_next_minute;

    cron_next_match_search #(
        .MAX_SEARCH_DAYS(SEARCH_DAYS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_now_year     (i_now_year),
        .i_now_month    (i_now_month),
        .i_now_day      (i_now_day),
        .i_now_weekday  (i_now_weekday),
        .i_now_hour     (i_now_hour),
        .i_now_minute   (i_now_minute),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_next_year    (o_next_year),
        .o_next_month   (o_next_month),
        .o_next_day     (o_next_day),
        .o_next_weekday (o_next_weekday),
        .o_next_hour    (o_next_hour),
        .o_next_minute  (o_next_minute)
    );

    // mirror of the mask registers, updated on each write beat
    logic [59:0] allow_minute;
    logic [23:0] allow_hour;
    logic [30:0] allow_mday;
    logic [11:0] allow_month;
    logic [6:0]  allow_wday;

    t_request pending_requests[$];
    t_match   expected_matches[$];

    int queries_sent = 0;
    int queries_taken = 0;
    int matches_seen = 0;
    int gave_up_seen = 0;
    int cfg_writes = 0;
    int err_count = 0;
    int idle_cycles = 0;
    bit burst = 1'b0;

    // driver scratch
    t_request drv_req;
    logic     drv_start;
    logic     drv_we;
    int       gap_left = 0;
    bit       gap_holds_idle = 1'b0;

    t_match want;
    t_now   seen_now;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int days_in(int y, int m);
        bit leap;
        leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        case (m) inside
            2:            return leap ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    // walk forward from the next whole minute until all five masks allow it or the day limit is passed
    function automatic t_match predict_next_match(t_now t);
        int y, m, d, w, h, mi, days;
        bit roll_hour, roll_day, hit;
        t_match r;
        y = int'(t.year);
        m = int'(t.month);
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        d = int'(t.day);
        if (d < 1) d = 1;
        if (d > days_in(y, m)) d = days_in(y, m);
        w = int'(t.wday) % 7;
        h = int'(t.hour);
        if (h > 23) h = 23;
        mi = int'(t.minute);
        if (mi > 59) mi = 59;
        days = 0;
        hit = 1'b0;
        roll_day = 1'b0;
        mi++;
        roll_hour = (mi > 59);
        while (1) begin
            if (roll_hour) begin
                mi = 0;
                h++;
                if (h > 23) begin
                    h = 0;
                    roll_day = 1'b1;
                end
                roll_hour = 1'b0;
            end
            if (roll_day) begin
                d++;
                w = (w + 1) % 7;
                if (d > days_in(y, m)) begin
                    d = 1;
                    m++;
                    if (m > 12) begin
                        m = 1;
                        y++;
                    end
                end
                days++;
                roll_day = 1'b0;
            end
            if (days > SEARCH_DAYS) break;
            if (!allow_month[m-1] || !allow_mday[d-1] || !allow_wday[w]) begin
                roll_day = 1'b1;
                h = 0;
                mi = 0;
                continue;
            end
            if (!allow_hour[h]) begin
                roll_hour = 1'b1;
                continue;
            end
            if (!allow_minute[mi]) begin
                mi++;
                if (mi > 59) roll_hour = 1'b1;
                continue;
            end
            hit = 1'b1;
            break;
        end
        r = '0;
        if (hit) begin
            r.found  = 1'b1;
            r.year   = y[11:0];
            r.month  = m[3:0];
            r.day    = d[4:0];
            r.wday   = w[2:0];
            r.hour   = h[4:0];
            r.minute = mi[5:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int got_v, input int want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got_v, want_v));
    endtask

    task automatic add_query(input int y, input int m, input int d, input int w,
                             input int h, input int mi);
        t_request r;
        r = '0;
        r.hurry = burst;
        r.hold_idle = 1'($urandom_range(0, 1));
        r.now.year = y[11:0];
        r.now.month = m[3:0];
        r.now.day = d[4:0];
        r.now.wday = w[2:0];
        r.now.hour = h[4:0];
        r.now.minute = mi[5:0];
        pending_requests.insert(pending_requests.size(), r);
    endtask

    task automatic add_cfg(input logic [cnms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [59:0] data);
        t_request r;
        r = '0;
        r.is_cfg = 1'b1;
        r.hurry = burst;
        r.idx = idx;
        r.data = data;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    // random mask at the given width, sometimes with junk above it
    function automatic logic [59:0] draw_mask(int width);
        logic [59:0] ones, r, m;
        ones = (60'd1 << width) - 60'd1;
        r = 60'({$urandom, $urandom});
        case ($urandom_range(0, 6))
            0:       m = ones;
            1:       m = 60'd1 << $urandom_range(0, width - 1);
            2:       m = r & 60'({$urandom, $urandom}) & 60'({$urandom, $urandom});
            3:       m = ones & ~(60'd1 << $urandom_range(0, width - 1));
            default: m = r | 60'({$urandom, $urandom});
        endcase
        m &= ones;
        if ($urandom_range(0, 3) == 0) m |= 60'({$urandom, $urandom}) & ~ones;
        return m;
    endfunction

    function automatic int draw_gap(t_request r);
        if (r.hurry) return 0;
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 11);
    endfunction

    // drive queries and register writes at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // hold start until the beat is taken
            drv_start = (queries_sent != queries_taken);
            drv_we = 1'b0;
            if (!drv_start) begin
                if (gap_left > 0) begin
                    if (!gap_holds_idle || !busy) gap_left--;
                end else if (pending_requests.size() > 0) begin
                    if (!pending_requests[0].is_cfg) begin
                        drv_req = pending_requests.pop_front();
                        drv_start = 1'b1;
                        queries_sent++;
                        i_now_year    <= drv_req.now.year;
                        i_now_month   <= drv_req.now.month;
                        i_now_day     <= drv_req.now.day;
                        i_now_weekday <= drv_req.now.wday;
                        i_now_hour    <= drv_req.now.hour;
                        i_now_minute  <= drv_req.now.minute;
                        gap_left = draw_gap(drv_req);
                        gap_holds_idle = drv_req.hold_idle;
                    end else if (expected_matches.size() == 0 && !busy) begin
                        // write masks only while the search is idle
                        drv_req = pending_requests.pop_front();
                        drv_we = 1'b1;
                        i_cfg_idx  <= drv_req.idx;
                        i_cfg_data <= drv_req.data;
                        gap_left = draw_gap(drv_req);
                        gap_holds_idle = 1'b0;
                    end
                end
            end
            start    <= drv_start;
            i_cfg_we <= drv_we;
        end
    end

    // sample beats at the rising edge: check results, track writes, predict
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            allow_minute = '1;
            allow_hour   = '1;
            allow_mday   = '1;
            allow_month  = '1;
            allow_wday   = '1;
        end else begin
            idle_cycles++;
            if (o_valid) begin
                idle_cycles = 0;
                if (expected_matches.size() == 0) begin
                    report_mismatch("result beat with no query outstanding");
                end else begin
                    want = expected_matches.pop_front();
                    check_field("found", int'(o_found), int'(want.found));
                    check_field("year", int'(o_next_year), int'(want.year));
                    check_field("month", int'(o_next_month), int'(want.month));
                    check_field("day", int'(o_next_day), int'(want.day));
                    check_field("weekday", int'(o_next_weekday), int'(want.wday));
                    check_field("hour", int'(o_next_hour), int'(want.hour));
                    check_field("minute", int'(o_next_minute), int'(want.minute));
                    if (want.found) matches_seen++;
                    else gave_up_seen++;
                end
            end
            if (i_cfg_we) begin
                idle_cycles = 0;
                cfg_writes++;
                case (i_cfg_idx)
                    cnms_pkg::CFG_MINUTE: allow_minute = i_cfg_data[59:0];
                    cnms_pkg::CFG_HOUR:   allow_hour   = i_cfg_data[23:0];
                    cnms_pkg::CFG_MDAY:   allow_mday   = i_cfg_data[30:0];
                    cnms_pkg::CFG_MONTH:  allow_month  = i_cfg_data[11:0];
                    cnms_pkg::CFG_WDAY:   allow_wday   = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                idle_cycles = 0;
                seen_now.year   = i_now_year;
                seen_now.month  = i_now_month;
                seen_now.day    = i_now_day;
                seen_now.wday   = i_now_weekday;
                seen_now.hour   = i_now_hour;
                seen_now.minute = i_now_minute;
                expected_matches.insert(expected_matches.size(),
                                        predict_next_match(seen_now));
                queries_taken++;
            end
            if (idle_cycles > HANG_LIMIT) begin
                $display("hang: no beat for %0d cycles", HANG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int phase, k, y;

        // rollovers and out-of-range fields with reset masks
        add_query(1970, 1, 1, 4, 0, 0);
        add_query(2399, 12, 31, 6, 23, 59);
        add_query(2100, 2, 28, 0, 23, 59);
        add_query(2000, 2, 28, 1, 23, 59);
        add_query(2024, 2, 29, 4, 23, 59);
        add_query(4095, 12, 31, 2, 23, 59);
        add_query(0, 0, 0, 7, 31, 63);
        add_query(2023, 15, 31, 3, 12, 30);
        add_query(2023, 4, 31, 3, 10, 5);
        add_query(2023, 2, 31, 5, 8, 59);

        // highest bit of every mask, junk above the hour and day-of-month register widths
        burst = 1'b1;
        add_cfg(cnms_pkg::CFG_MINUTE, 60'd1 << 59);
        add_cfg(cnms_pkg::CFG_HOUR, {36'hFFFFFFFFF, 24'h800000});
        add_query(2020, 6, 15, 1, 0, 0);
        add_query(2020, 6, 15, 1, 23, 59);
        add_cfg(cnms_pkg::CFG_MDAY, {29'h1FFFFFFF, 31'h40000000});
        add_cfg(cnms_pkg::CFG_MONTH, 60'h800);
        add_cfg(cnms_pkg::CFG_WDAY, 60'h40);
        add_query(2020, 1, 1, 3, 0, 0);

        // a date that never exists: search gives up
        burst = 1'b0;
        add_cfg(cnms_pkg::CFG_MINUTE, '1);
        add_cfg(cnms_pkg::CFG_HOUR, '1);
        add_cfg(cnms_pkg::CFG_WDAY, '1);
        add_cfg(cnms_pkg::CFG_MONTH, 60'h2);
        add_cfg(cnms_pkg::CFG_MDAY, 60'd1 << 29);
        add_query(2021, 3, 10, 3, 4, 4);

        // leap day just inside the day limit, across a non-leap century
        add_cfg(cnms_pkg::CFG_MDAY, 60'd1 << 28);
        add_cfg(CFG_SPARE_LO, 60'd0);
        add_cfg(CFG_SPARE_HI, 60'd0);
        add_query(2096, 3, 1, 4, 0, 0);
        add_query(2096, 2, 29, 3, 23, 59);

        // empty minute mask, then day of month and weekday both required
        add_cfg(cnms_pkg::CFG_MINUTE, 60'd0);
        add_query(2030, 7, 4, 4, 12, 0);
        add_cfg(cnms_pkg::CFG_MINUTE, 60'd1);
        add_cfg(cnms_pkg::CFG_MONTH, '1);
        add_cfg(cnms_pkg::CFG_MDAY, 60'd1 << 12);
        add_cfg(cnms_pkg::CFG_WDAY, 60'd1 << 5);
        add_query(2025, 1, 1, 3, 0, 0);

        // random phases, each with a fresh set of masks
        for (phase = 0; phase < 10; phase++) begin
            burst = ($urandom_range(0, 2) == 0);
            if (phase == 0) begin
                add_cfg(cnms_pkg::CFG_MINUTE, '1);
                add_cfg(cnms_pkg::CFG_HOUR, '1);
                add_cfg(cnms_pkg::CFG_MDAY, '1);
                add_cfg(cnms_pkg::CFG_MONTH, '1);
                add_cfg(cnms_pkg::CFG_WDAY, '1);
            end else begin
                add_cfg(cnms_pkg::CFG_MINUTE, draw_mask(60));
                add_cfg(cnms_pkg::CFG_HOUR, draw_mask(24));
                add_cfg(cnms_pkg::CFG_MDAY, draw_mask(31));
                add_cfg(cnms_pkg::CFG_MONTH, draw_mask(12));
                add_cfg(cnms_pkg::CFG_WDAY, draw_mask(7));
                if ($urandom_range(0, 2) == 0)
                    add_cfg(3'($urandom_range(5, 7)), 60'({$urandom, $urandom}));
            end
            for (k = 0; k < 12; k++) begin
                y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(1970, 2399);
                if ($urandom_range(0, 7) == 0)
                    add_query(y, $urandom_range(0, 15), $urandom_range(0, 31),
                              $urandom_range(0, 7), $urandom_range(0, 31),
                              $urandom_range(0, 63));
                else if ($urandom_range(0, 3) == 0)
                    add_query(y, $urandom_range(1, 12), $urandom_range(27, 31),
                              $urandom_range(0, 6), 23, 59);
                else
                    add_query(y, $urandom_range(1, 12), $urandom_range(1, 31),
                              $urandom_range(0, 6), $urandom_range(0, 23),
                              $urandom_range(0, 59));
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || queries_sent != queries_taken ||
               expected_matches.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d queries over %0d mask writes: %0d matched, %0d gave up",
                 queries_taken, cfg_writes, matches_seen, gave_up_seen);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
